### rtl/pts_pkg.sv
// Shared types and constants of the particle transport step unit.
package pts_pkg;

    localparam int DIR_W    = 16;
    localparam int POS_IO_W = 32;
    localparam int CFG_W    = 31;
    localparam int CNT_IO_W = 16;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_MOVE    = 2'd1;
    localparam logic [1:0] MODE_SCATTER = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam logic REG_STEP   = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    localparam logic [CFG_W-1:0] STEP_RESET   = 31'd65536;
    localparam logic [CFG_W-1:0] RADIUS_RESET = 31'd6553600;

    typedef logic signed [DIR_W-1:0] t_dir;

    typedef struct packed {
        logic start;
        t_dir a;
        t_dir b;
        t_dir c;
    } t_norm_req;

    typedef struct packed {
        logic done;
        t_dir dx;
        t_dir dy;
        t_dir dz;
    } t_norm_rsp;

endpackage

### rtl/pts_norm_unit.sv
// Bit-serial direction normalizer: squares, square root and three divisions.
module pts_norm_unit import pts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_norm_req i_req,
    output t_norm_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [4:0] SQR_LAST  = 5'd15;
    localparam logic [4:0] ROOT_LAST = 5'd29;
    localparam logic [4:0] DIV_LAST  = 5'd14;
    localparam logic [14:0] Q_CAP    = 15'd16384;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_cnt;
    logic [15:0] r_mp   [3];
    logic [31:0] r_mc   [3];
    logic [31:0] r_acc  [3];
    logic        r_neg  [3];
    logic [59:0] r_rad;
    logic [31:0] r_rem;
    logic [29:0] r_root;
    logic [29:0] r_drem [3];
    logic [14:0] r_dnum [3];
    logic [14:0] r_quo  [3];
    t_dir        r_out  [3];
    logic        r_done;

    t_dir        w_in   [3];
    logic [33:0] w_rsh;
    logic [33:0] w_trial;
    logic [32:0] w_sum;
    logic [44:0] w_num  [3];
    logic [30:0] w_dsh  [3];
    logic [14:0] w_qcap [3];

    assign w_in[0] = i_req.a;
    assign w_in[1] = i_req.b;
    assign w_in[2] = i_req.c;

    always_comb begin
        w_rsh   = {r_rem, r_rad[59:58]};
        w_trial = {2'b00, r_root, 2'b01};
        w_sum   = {1'b0, r_acc[0]} + {1'b0, r_acc[1]} + {1'b0, r_acc[2]};
        for (int k = 0; k < 3; k++) begin
            w_num[k]  = {1'b0, r_mp[k], 28'd0} + {16'd0, r_root[29:1]};
            w_dsh[k]  = {r_drem[k], r_dnum[k][14]};
            w_qcap[k] = (r_quo[k] > Q_CAP) ? Q_CAP : r_quo[k];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req.start) n_state = S_SQR;
            S_SQR:  if (r_cnt == 5'd0) n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: if (r_cnt == 5'd0) n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd0) n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= w_in[k][15];
                    r_mp[k]  <= w_in[k][15] ? 16'(-w_in[k]) : 16'(w_in[k]);
                    r_mc[k]  <= w_in[k][15] ? {16'd0, 16'(-w_in[k])} : {16'd0, 16'(w_in[k])};
                    r_acc[k] <= '0;
                end
                r_cnt <= SQR_LAST;
            end
            S_SQR: begin
                // mp is kept intact for the divider; the counter picks its bits and mc is shifted into place
                for (int k = 0; k < 3; k++) begin
                    if (r_mp[k][15 - r_cnt[3:0]])
                        r_acc[k] <= r_acc[k] + (r_mc[k] << (15 - r_cnt[3:0]));
                end
                r_cnt <= r_cnt - 5'd1;
            end
            S_SUM: begin
                r_rad  <= {w_sum[31:0], 28'd0};
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= ROOT_LAST;
            end
            S_ROOT: begin
                if (w_rsh >= w_trial) begin
                    r_rem  <= 32'(w_rsh - w_trial);
                    r_root <= {r_root[28:0], 1'b1};
                end else begin
                    r_rem  <= w_rsh[31:0];
                    r_root <= {r_root[28:0], 1'b0};
                end
                r_rad <= {r_rad[57:0], 2'b00};
                r_cnt <= r_cnt - 5'd1;
            end
            S_PREP: begin
                for (int k = 0; k < 3; k++) begin
                    r_drem[k] <= w_num[k][44:15];
                    r_dnum[k] <= w_num[k][14:0];
                    r_quo[k]  <= '0;
                end
                r_cnt <= DIV_LAST;
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (w_dsh[k] >= {1'b0, r_root}) begin
                        r_drem[k] <= 30'(w_dsh[k] - {1'b0, r_root});
                        r_quo[k]  <= {r_quo[k][13:0], 1'b1};
                    end else begin
                        r_drem[k] <= w_dsh[k][29:0];
                        r_quo[k]  <= {r_quo[k][13:0], 1'b0};
                    end
                    r_dnum[k] <= {r_dnum[k][13:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            S_DONE: begin
                for (int k = 0; k < 3; k++)
                    r_out[k] <= r_neg[k] ? -$signed({1'b0, w_qcap[k]}) : $signed({1'b0, w_qcap[k]});
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.dx   = r_out[0];
    assign o_rsp.dy   = r_out[1];
    assign o_rsp.dz   = r_out[2];

`ifndef ASSERT_OFF
    a_root_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_root != 30'd0))
        else $error("zero divisor in normalizer");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_DONE))
        else $error("done without finishing divide");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQR && $past(r_state) == S_IDLE) |-> $past(i_req.start))
        else $error("normalizer left idle without start");
`endif

endmodule

### rtl/particle_transport_step_unit.sv
// Top level of the particle transport step unit: control, move, scatter and sphere test.
// Usage:
//   Input channel (i_valid/o_ready) carries one item: mode plus load position and
//   direction (the direction fields double as the random draw of a scatter).
//   Output channel (o_valid/i_ready) returns exactly one beat per item: the held
//   position, direction, alive flag, scatter count and the zero-draw flag.
//   step_length (0x0) and sphere_radius (0x4) are to be written on the APB port only
//   while the unit is idle; the unit itself does not enforce this.
// Work per item:
//   a load item passes through the load state to finish; a no-op item, a move or
//   scatter on a dead particle and a scatter of a zero draw go straight to finish;
//   move runs a 16-step shift-add multiply and a 31-step shift-add squaring for the
//   sphere test; scatter runs the 16-step squaring, the 30-step square root and
//   the 15-step divide of the normalizer. One item is in work at a time.
// The result register decouples the sides: a new item is taken while an older
// beat waits; an item that finishes while the register is still full holds
// until the receiver takes the older beat.
// Reset clears the particle, the count and the valid flags and restores the
// register defaults.
module particle_transport_step_unit import pts_pkg::*; #(
    parameter int POSITION_BITS = 32,
    parameter int COUNT_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic signed [31:0] i_in_pos_x,
    input  logic signed [31:0] i_in_pos_y,
    input  logic signed [31:0] i_in_pos_z,
    input  logic signed [15:0] i_in_dir_x,
    input  logic signed [15:0] i_in_dir_y,
    input  logic signed [15:0] i_in_dir_z,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [15:0] o_out_dir_x,
    output logic signed [15:0] o_out_dir_y,
    output logic signed [15:0] o_out_dir_z,
    output logic              o_out_alive,
    output logic [15:0]       o_out_scatters,
    output logic              o_out_degenerate,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int P  = POSITION_BITS;
    localparam int SW = ((P > 34) ? P : 34) + 1;
    localparam logic signed [SW-1:0] POS_HI = {{(SW-P+1){1'b0}}, {(P-1){1'b1}}};
    localparam logic signed [SW-1:0] POS_LO = ~POS_HI;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_POS  = 4'd3;
    localparam logic [3:0] S_SQI  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_SCAT = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam logic [4:0] MUL_LAST = 5'd15;
    localparam logic [4:0] SQ_LAST  = 5'd30;

    logic [3:0]             r_state;
    logic [4:0]             r_bits;
    logic [CFG_W-1:0]       r_step, r_radius;
    logic signed [P-1:0]    r_pos    [3];
    t_dir                   r_dir    [3];
    logic                   r_alive;
    logic [COUNT_BITS-1:0]  r_count;
    logic                   r_degen;
    logic signed [31:0]     r_in_pos [3];
    t_dir                   r_in_dir [3];
    logic [15:0]            r_mmp    [3];
    logic [46:0]            r_mmc    [3];
    logic [46:0]            r_macc   [3];
    logic                   r_mneg   [3];
    logic [30:0]            r_smp    [4];
    logic [61:0]            r_smc    [4];
    logic [61:0]            r_sacc   [4];
    logic                   r_axis_out;
    logic [62:0]            r_s2;
    logic                   r_req_start;
    logic                   r_ovalid;
    logic signed [31:0]     r_o_pos  [3];
    t_dir                   r_o_dir  [3];
    logic                   r_o_alive;
    logic [15:0]            r_o_cnt;
    logic                   r_o_degen;

    logic                   w_in_acc;
    logic                   w_cfg_wr;
    logic                   w_out_load;
    logic [46:0]            w_mrnd   [3];
    logic signed [SW-1:0]   w_sum    [3];
    logic signed [P-1:0]    w_sat    [3];
    logic [P-1:0]           w_ax     [3];
    logic [P+30:0]          w_axw    [3];
    logic [P+30:0]          w_rw;
    logic                   w_zero_draw;
    logic [63:0]            w_sq_tot;
    logic [P+31:0]          w_pos_ext [3];
    logic [COUNT_BITS+15:0] w_cnt_ext;
    t_norm_req              w_req;
    t_norm_rsp              w_rsp;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_out_load = (r_state == S_FIN) && (!r_ovalid || i_ready);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_RADIUS) ? {1'b0, r_radius} : {1'b0, r_step};
    assign w_zero_draw = (i_in_dir_x == '0) && (i_in_dir_y == '0) && (i_in_dir_z == '0);
    assign w_rw       = {{P{1'b0}}, r_radius};
    assign w_cnt_ext  = {16'd0, r_count};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mrnd[k] = r_macc[k] + 47'd8192;
            if (r_state == S_LOAD)
                w_sum[k] = SW'(r_in_pos[k]);
            else if (r_mneg[k])
                w_sum[k] = SW'(r_pos[k]) - SW'($signed({1'b0, w_mrnd[k][46:14]}));
            else
                w_sum[k] = SW'(r_pos[k]) + SW'($signed({1'b0, w_mrnd[k][46:14]}));
            if (w_sum[k] > POS_HI)
                w_sat[k] = POS_HI[P-1:0];
            else if (w_sum[k] < POS_LO)
                w_sat[k] = POS_LO[P-1:0];
            else
                w_sat[k] = w_sum[k][P-1:0];
            w_ax[k]      = r_pos[k][P-1] ? P'(-r_pos[k]) : P'(r_pos[k]);
            w_axw[k]     = {31'd0, w_ax[k]};
            w_pos_ext[k] = {{32{r_pos[k][P-1]}}, r_pos[k]};
        end
        w_sq_tot = {1'b0, r_s2} + {2'b00, r_sacc[2]};
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= STEP_RESET;
            r_radius <= RADIUS_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_STEP) r_step <= pwdata[CFG_W-1:0];
            else                      r_radius <= pwdata[CFG_W-1:0];
        end
    end

    // control and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alive     <= 1'b0;
            r_count     <= '0;
            r_req_start <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_dir[k] <= '0;
            end
        end else begin
            r_req_start <= 1'b0;
            if (w_out_load)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_mode == MODE_LOAD) begin
                            r_state <= S_LOAD;
                        end else if (i_mode == MODE_MOVE && r_alive) begin
                            r_state <= S_MUL;
                        end else if (i_mode == MODE_SCATTER && r_alive) begin
                            if (r_count != '1) r_count <= r_count + 1'b1;
                            if (w_zero_draw) begin
                                r_state <= S_FIN;
                            end else begin
                                r_req_start <= 1'b1;
                                r_state     <= S_SCAT;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_LOAD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pos[k] <= w_sat[k];
                        r_dir[k] <= r_in_dir[k];
                    end
                    r_alive <= 1'b1;
                    r_count <= '0;
                    r_state <= S_FIN;
                end
                S_MUL:  if (r_bits == 5'd0) r_state <= S_POS;
                S_POS: begin
                    for (int k = 0; k < 3; k++) r_pos[k] <= w_sat[k];
                    r_state <= S_SQI;
                end
                S_SQI:  r_state <= S_SQ;
                S_SQ:   if (r_bits == 5'd0) r_state <= S_SUM;
                S_SUM:  r_state <= S_CMP;
                S_CMP: begin
                    if (r_axis_out || (w_sq_tot > {2'b00, r_sacc[3]})) r_alive <= 1'b0;
                    r_state <= S_FIN;
                end
                S_SCAT: begin
                    if (w_rsp.done) begin
                        r_dir[0] <= w_rsp.dx;
                        r_dir[1] <= w_rsp.dy;
                        r_dir[2] <= w_rsp.dz;
                        r_state  <= S_FIN;
                    end
                end
                S_FIN:  if (w_out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // serial datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_degen     <= (i_mode == MODE_SCATTER) && r_alive && w_zero_draw;
            r_in_pos[0] <= i_in_pos_x;
            r_in_pos[1] <= i_in_pos_y;
            r_in_pos[2] <= i_in_pos_z;
            r_in_dir[0] <= i_in_dir_x;
            r_in_dir[1] <= i_in_dir_y;
            r_in_dir[2] <= i_in_dir_z;
            for (int k = 0; k < 3; k++) begin
                r_mneg[k] <= r_dir[k][15];
                r_mmp[k]  <= r_dir[k][15] ? 16'(-r_dir[k]) : 16'(r_dir[k]);
                r_mmc[k]  <= {16'd0, r_step};
                r_macc[k] <= '0;
            end
            r_bits <= MUL_LAST;
        end else if (r_state == S_MUL) begin
            for (int k = 0; k < 3; k++) begin
                if (r_mmp[k][0]) r_macc[k] <= r_macc[k] + r_mmc[k];
                r_mmp[k] <= {1'b0, r_mmp[k][15:1]};
                r_mmc[k] <= {r_mmc[k][45:0], 1'b0};
            end
            r_bits <= r_bits - 5'd1;
        end else if (r_state == S_SQI) begin
            // squares only matter when every axis is within the radius
            r_axis_out <= (w_axw[0] > w_rw) || (w_axw[1] > w_rw) || (w_axw[2] > w_rw);
            for (int k = 0; k < 3; k++) begin
                r_smp[k]  <= w_axw[k][30:0];
                r_smc[k]  <= {31'd0, w_axw[k][30:0]};
                r_sacc[k] <= '0;
            end
            r_smp[3]  <= r_radius;
            r_smc[3]  <= {31'd0, r_radius};
            r_sacc[3] <= '0;
            r_bits    <= SQ_LAST;
        end else if (r_state == S_SQ) begin
            for (int k = 0; k < 4; k++) begin
                if (r_smp[k][0]) r_sacc[k] <= r_sacc[k] + r_smc[k];
                r_smp[k] <= {1'b0, r_smp[k][30:1]};
                r_smc[k] <= {r_smc[k][60:0], 1'b0};
            end
            r_bits <= r_bits - 5'd1;
        end else if (r_state == S_SUM) begin
            r_s2 <= {1'b0, r_sacc[0]} + {1'b0, r_sacc[1]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int k = 0; k < 3; k++) begin
                r_o_pos[k] <= w_pos_ext[k][31:0];
                r_o_dir[k] <= r_dir[k];
            end
            r_o_alive <= r_alive;
            r_o_cnt   <= w_cnt_ext[15:0];
            r_o_degen <= r_degen;
        end
    end

    assign w_req.start = r_req_start;
    assign w_req.a     = r_in_dir[0];
    assign w_req.b     = r_in_dir[1];
    assign w_req.c     = r_in_dir[2];

    pts_norm_unit u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_valid          = r_ovalid;
    assign o_out_pos_x      = r_o_pos[0];
    assign o_out_pos_y      = r_o_pos[1];
    assign o_out_pos_z      = r_o_pos[2];
    assign o_out_dir_x      = r_o_dir[0];
    assign o_out_dir_y      = r_o_dir[1];
    assign o_out_dir_z      = r_o_dir[2];
    assign o_out_alive      = r_o_alive;
    assign o_out_scatters   = r_o_cnt;
    assign o_out_degenerate = r_o_degen;

`ifndef ASSERT_OFF
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_FIN))
        else $error("result beat raised outside finish");
    a_alive_by_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_alive) |-> $past(r_state == S_LOAD))
        else $error("particle revived without load");
    a_norm_done_scat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_SCAT))
        else $error("normalizer finished outside scatter");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 1'b1 || r_count == '0))
        else $error("scatter count jumped");
`endif

endmodule
